FILE: rtl/ictl_pkg.sv
package ictl_pkg;

  localparam int CONN_W    = 6;
  localparam int EVT_W     = 32;
  localparam int LIMIT_W   = 32;
  localparam int S_TDATA_W = 40;  // conn_id, event_time, zero pad
  localparam int S_TUSER_W = 2;   // cmd
  localparam int M_TDATA_W = 8;   // conn_id_out, zero pad

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 32'd10;

  typedef enum logic [1:0] {
    CMD_OPEN     = 2'd0,
    CMD_CLOSE    = 2'd1,
    CMD_ACTIVITY = 2'd2,
    CMD_TICK     = 2'd3
  } cmd_t;

endpackage

FILE: rtl/ictl_ram.sv
module ictl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/idle_connection_timeout_list.sv
// Channel   Dir  Handshake                      Payload
// s_axis    in   s_axis_tvalid / s_axis_tready  tdata: conn_id, event_time; tuser: cmd
// m_axis    out  m_axis_tvalid / m_axis_tready  tdata: conn_id_out; tlast: last
// cfg       in   cfg_valid / cfg_ready          cfg_data: idle_limit
//
// Open and close run in ST_EXEC; activity also runs ST_APPEND (unlink, then
// append at the tail). Tick: an empty list leaves the block idle, else the
// walk follows the next links through the next-link RAM, one registered read per entry.
// Ignored commands (bad slot, open of a listed slot, etc.) keep the block idle.
// Each shutdown beat is held one entry back so tlast can be set; a full
// output register stalls the walk. Reset is synchronous; the RAMs are not cleared.
module idle_connection_timeout_list #(
  parameter int MAX_CONN  = 64,
  parameter int TIME_BITS = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [ictl_pkg::S_TDATA_W-1:0] s_axis_tdata,  // [5:0] conn_id, [37:6] event_time
  input  logic [ictl_pkg::S_TUSER_W-1:0] s_axis_tuser,  // [1:0] cmd
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [ictl_pkg::M_TDATA_W-1:0] m_axis_tdata,  // [5:0] conn_id_out
  output logic                           m_axis_tlast,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [ictl_pkg::LIMIT_W-1:0]   cfg_data
);

  import ictl_pkg::*;

  localparam int LW    = $clog2(MAX_CONN);
  localparam int CW    = $clog2(MAX_CONN + 1);
  localparam int CMP_W = (TIME_BITS > LIMIT_W) ? TIME_BITS : LIMIT_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_APPEND,
    ST_WALK,
    ST_FLUSH
  } state_t;

  function automatic logic [LW-1:0] link_ix(input logic [LW-1:0] v);
    return (int'(v) < MAX_CONN) ? v : '0;
  endfunction

  state_t               state;
  cmd_t                 cmd_r;
  logic [LW-1:0]        id_r;
  logic [TIME_BITS-1:0] now_r;
  logic [LIMIT_W-1:0]   idle_limit;
  logic [MAX_CONN-1:0]  listed;
  logic [LW-1:0]        head;
  logic [LW-1:0]        tail;
  logic [CW-1:0]        count;
  logic [LW-1:0]        cur;
  logic [CW-1:0]        remaining;
  logic                 pend_valid;
  logic [LW-1:0]        pend_id;
  logic                 out_valid;
  logic [CONN_W-1:0]    out_id;
  logic                 out_last;

  // input fields
  cmd_t              in_cmd;
  logic [CONN_W-1:0] in_conn_id;
  logic [EVT_W-1:0]  in_time;
  logic              in_fire;
  logic              in_id_ok;
  logic [LW-1:0]     in_id;

  assign in_cmd     = cmd_t'(s_axis_tuser);
  assign in_conn_id = s_axis_tdata[CONN_W-1:0];
  assign in_time    = s_axis_tdata[CONN_W +: EVT_W];
  assign in_fire    = s_axis_tvalid && s_axis_tready;
  assign in_id_ok   = {1'b0, in_conn_id} < (CONN_W + 1)'(MAX_CONN);
  assign in_id      = LW'(in_conn_id);

  // RAM ports
  logic                 rd_en;
  logic [LW-1:0]        rd_addr;
  logic [TIME_BITS-1:0] rd_time;
  logic [LW-1:0]        rd_next;
  logic [LW-1:0]        rd_prev;
  logic                 time_we;
  logic [LW-1:0]        time_waddr;
  logic                 next_we;
  logic [LW-1:0]        next_waddr;
  logic [LW-1:0]        next_wdata;
  logic                 prev_we;
  logic [LW-1:0]        prev_waddr;
  logic [LW-1:0]        prev_wdata;

  ictl_ram #(.WIDTH(TIME_BITS), .DEPTH(MAX_CONN)) u_time_ram (
    .clk(clk), .we(time_we), .waddr(time_waddr), .wdata(now_r),
    .re(rd_en), .raddr(rd_addr), .rdata(rd_time)
  );

  ictl_ram #(.WIDTH(LW), .DEPTH(MAX_CONN)) u_next_ram (
    .clk(clk), .we(next_we), .waddr(next_waddr), .wdata(next_wdata),
    .re(rd_en), .raddr(rd_addr), .rdata(rd_next)
  );

  ictl_ram #(.WIDTH(LW), .DEPTH(MAX_CONN)) u_prev_ram (
    .clk(clk), .we(prev_we), .waddr(prev_waddr), .wdata(prev_wdata),
    .re(rd_en), .raddr(rd_addr), .rdata(rd_prev)
  );

  // unlink neighbors from the slot's links
  logic [LW-1:0] nx;
  logic [LW-1:0] pv;
  assign nx = link_ix(rd_next);
  assign pv = link_ix(rd_prev);

  // walk evaluation
  logic [TIME_BITS-1:0] age;
  logic                 age_neg;
  logic                 expired;
  logic                 stop;
  logic                 can_push;
  logic                 step_go;
  logic                 walk_end;
  logic                 out_push;

  assign age      = now_r - rd_time;
  assign age_neg  = age[TIME_BITS-1];
  assign expired  = !age_neg && (CMP_W'(age) > CMP_W'(idle_limit));
  assign stop     = !age_neg && !expired;
  assign can_push = !out_valid || m_axis_tready;
  assign step_go  = !(expired && pend_valid && !can_push);
  assign walk_end = stop || (remaining == CW'(1));
  assign out_push = ((state == ST_WALK) && step_go && expired && pend_valid) ||
                    ((state == ST_FLUSH) && pend_valid && can_push);

  always_comb begin
    rd_en      = 1'b0;
    rd_addr    = '0;
    time_we    = 1'b0;
    time_waddr = id_r;
    next_we    = 1'b0;
    next_waddr = tail;
    next_wdata = id_r;
    prev_we    = 1'b0;
    prev_waddr = id_r;
    prev_wdata = tail;
    unique case (state)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_cmd == CMD_TICK) begin
            rd_en   = 1'b1;
            rd_addr = link_ix(head);
          end else begin
            rd_en   = in_id_ok;
            rd_addr = in_id;
          end
        end
      end
      ST_EXEC: begin
        time_we = (cmd_r != CMD_CLOSE);
        if (cmd_r == CMD_OPEN) begin
          next_we = (count != '0);
          prev_we = (count != '0);
        end else begin
          next_we    = (id_r != head);
          next_waddr = pv;
          next_wdata = nx;
          prev_we    = (id_r != tail);
          prev_waddr = nx;
          prev_wdata = pv;
        end
      end
      ST_APPEND: begin
        next_we = (count != '0);
        prev_we = (count != '0);
      end
      ST_WALK: begin
        if (step_go) begin
          time_we    = age_neg;
          time_waddr = cur;
          if (!walk_end) begin
            rd_en   = 1'b1;
            rd_addr = link_ix(rd_next);
          end
        end
      end
      ST_FLUSH: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      idle_limit <= LIMIT_RESET;
      listed     <= '0;
      head       <= '0;
      tail       <= '0;
      count      <= '0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_valid) begin
        idle_limit <= cfg_data;
      end
      if (out_push) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_fire) begin
            cmd_r <= in_cmd;
            id_r  <= in_id;
            now_r <= TIME_BITS'(in_time);
            if (in_cmd == CMD_TICK) begin
              if (count != '0) begin
                cur        <= link_ix(head);
                remaining  <= count;
                pend_valid <= 1'b0;
                state      <= ST_WALK;
              end
            end else if (in_id_ok && ((in_cmd == CMD_OPEN) != listed[in_id])) begin
              state <= ST_EXEC;
            end
          end
        end
        ST_EXEC: begin
          if (cmd_r == CMD_OPEN) begin
            if (count == '0) begin
              head <= id_r;
            end
            tail         <= id_r;
            listed[id_r] <= 1'b1;
            count        <= count + CW'(1);
            state        <= ST_IDLE;
          end else begin
            if (id_r == head) begin
              head <= nx;
            end
            if (id_r == tail) begin
              tail <= pv;
            end
            listed[id_r] <= 1'b0;
            count        <= count - CW'(1);
            state        <= (cmd_r == CMD_ACTIVITY) ? ST_APPEND : ST_IDLE;
          end
        end
        ST_APPEND: begin
          if (count == '0) begin
            head <= id_r;
          end
          tail         <= id_r;
          listed[id_r] <= 1'b1;
          count        <= count + CW'(1);
          state        <= ST_IDLE;
        end
        ST_WALK: begin
          if (step_go) begin
            if (expired) begin
              if (pend_valid) begin
                out_id    <= CONN_W'(pend_id);
                out_last  <= 1'b0;
              end
              pend_id    <= cur;
              pend_valid <= 1'b1;
            end
            if (walk_end) begin
              state <= ST_FLUSH;
            end else begin
              cur       <= link_ix(rd_next);
              remaining <= remaining - CW'(1);
            end
          end
        end
        ST_FLUSH: begin
          if (!pend_valid) begin
            state <= ST_IDLE;
          end else if (can_push) begin
            out_id     <= CONN_W'(pend_id);
            out_last   <= 1'b1;
            pend_valid <= 1'b0;
            state      <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign s_axis_tready = (state == ST_IDLE);
  assign cfg_ready     = 1'b1;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = M_TDATA_W'(out_id);
  assign m_axis_tlast  = out_last;

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    int'(count) <= MAX_CONN)
    else $error("list count beyond slot count");

  a_count_listed: assert property (@(posedge clk) disable iff (rst)
    $countones(listed) == int'(count))
    else $error("list count disagrees with listed slots");

  a_pend_in_walk: assert property (@(posedge clk) disable iff (rst)
    pend_valid |-> (state == ST_WALK || state == ST_FLUSH))
    else $error("pending shutdown left outside a tick walk");

  a_walk_remaining: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WALK) |-> (remaining != '0))
    else $error("walk running with no entries left");

  a_push_while_full: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !m_axis_tready) |=> $stable(out_id) && $stable(out_last))
    else $error("held shutdown beat overwritten");

endmodule
